@@ rtl/ebeu_pkg.sv @@
// Package with shared types, codes and reset constants of the encoder and button event unit.
`timescale 1ns / 1ps
`default_nettype none

package ebeu_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int NUM_BUTTONS = 4;
    localparam int BTN_KNOB    = 3;

    localparam logic [15:0] BUTTON_LOCKOUT_RESET = 16'd20;
    localparam logic [15:0] KNOB_LOCKOUT_RESET   = 16'd200;

    typedef enum logic [1:0] {
        CMD_SAMPLE      = 2'd0,
        CMD_POLL_BUTTON = 2'd1,
        CMD_POLL_ROTARY = 2'd2
    } t_cmd;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SAVE  = 2'd1;
    localparam logic [1:0] EV_BACK  = 2'd2;
    localparam logic [1:0] EV_PAUSE = 2'd3;
    localparam logic [1:0] EV_PUSH  = 2'd1;
    localparam logic [1:0] EV_CW    = 2'd2;
    localparam logic [1:0] EV_CCW   = 2'd3;

    localparam logic REG_BUTTON_LOCKOUT = 1'b0;
    localparam logic REG_KNOB_LOCKOUT   = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ticks;
        logic        enc_a;
        logic        enc_b;
        logic [3:0]  button_falls;
    } t_item;

    typedef struct packed {
        logic [15:0] button_lockout;
        logic [15:0] knob_lockout;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/encoder_and_button_event_unit.sv @@
// Top level of the encoder and button event unit: input register, core and result register.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_cmd, i_now_ticks, i_enc_a, i_enc_b,
//                                            i_button_falls
//  result    out        o_valid / i_stall    o_event_res, o_position
//  config    in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One transaction per clock is taken while o_stall is low. A poll passes from the input
// register through the core logic, which feeds its result into the result register. A sample
// gives no result. Reset clears the valid flags and resets all decoder state.
// A stalled result holds the input register only when it holds a poll; samples still pass.
`timescale 1ns / 1ps
`default_nettype none

module encoder_and_button_event_unit
    import ebeu_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic        [1:0]  i_cmd,
    input  wire logic        [31:0] i_now_ticks,
    input  wire logic               i_enc_a,
    input  wire logic               i_enc_b,
    input  wire logic        [3:0]  i_button_falls,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic             [1:0]  o_event_res,
    output logic signed      [15:0] o_position,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [2:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    t_cfg        cfg;
    t_item       r_item;
    logic        r_in_valid;
    logic        r_out_valid;
    logic [1:0]  r_event_res;
    logic [15:0] r_position;
    logic        has_result;
    logic [1:0]  core_event;
    logic [15:0] core_position;
    logic        out_free;
    logic        fire;
    logic        accept;

    ebeu_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ebeu_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_item),
        .i_cfg        (cfg),
        .o_has_result (has_result),
        .o_event_res  (core_event),
        .o_position   (core_position)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && (!has_result || out_free);
    assign o_stall  = r_in_valid && !fire;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.cmd          <= i_cmd;
            r_item.now_ticks    <= i_now_ticks;
            r_item.enc_a        <= i_enc_a;
            r_item.enc_b        <= i_enc_b;
            r_item.button_falls <= i_button_falls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_result) begin
            r_event_res <= core_event;
            r_position  <= core_position;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_event_res = r_event_res;
    assign o_position  = $signed(r_position);

`ifndef ASSERT_OFF
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && has_result && r_out_valid))
        else $error("input stalled without a blocked poll");

    a_poll_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && has_result) |=> o_valid)
        else $error("processed poll did not produce a result");

    a_sample_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(fire && has_result) && (!o_valid || !i_stall)) |=> !o_valid)
        else $error("result appeared without a processed poll");
`endif

endmodule

`default_nettype wire

@@ rtl/ebeu_cfg_regs.sv @@
// Configuration register file with an APB-style write and read port.
`timescale 1ns / 1ps
`default_nettype none

module ebeu_cfg_regs
    import ebeu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [15:0] r_button_lockout;
    logic [15:0] r_knob_lockout;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_lockout <= BUTTON_LOCKOUT_RESET;
            r_knob_lockout   <= KNOB_LOCKOUT_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_BUTTON_LOCKOUT) begin
                r_button_lockout <= pwdata[15:0];
            end else begin
                r_knob_lockout <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_BUTTON_LOCKOUT) begin
            prdata = {16'd0, r_button_lockout};
        end else begin
            prdata = {16'd0, r_knob_lockout};
        end
    end

    assign o_cfg.button_lockout = r_button_lockout;
    assign o_cfg.knob_lockout   = r_knob_lockout;

endmodule

`default_nettype wire

@@ rtl/ebeu_core.sv @@
// Encoder decoding, button lockout and event poll logic with its state registers.
`timescale 1ns / 1ps
`default_nettype none

module ebeu_core
    import ebeu_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_item       i_item,
    input  wire t_cfg        i_cfg,
    output logic             o_has_result,
    output logic      [1:0]  o_event_res,
    output logic      [15:0] o_position
);

    logic                   r_prev_a;
    logic [COUNT_WIDTH-1:0] r_knob;
    logic [COUNT_WIDTH-1:0] r_reported;
    logic [TIME_WIDTH-1:0]  r_time    [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_pending;

    logic                   n_prev_a;
    logic [COUNT_WIDTH-1:0] n_knob;
    logic [COUNT_WIDTH-1:0] n_reported;
    logic [TIME_WIDTH-1:0]  n_time    [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] n_pending;

    logic [TIME_WIDTH-1:0]  now_t;
    logic [TIME_WIDTH-1:0]  elapsed   [NUM_BUTTONS];
    logic [TIME_WIDTH-1:0]  lockout   [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] diff;
    logic [31:0]            knob_ext;

    assign now_t    = i_item.now_ticks[TIME_WIDTH-1:0];
    assign diff     = r_knob - r_reported;
    assign knob_ext = 32'(r_knob);

    always_comb begin
        n_prev_a     = r_prev_a;
        n_knob       = r_knob;
        n_reported   = r_reported;
        n_pending    = r_pending;
        o_has_result = 1'b0;
        o_event_res  = EV_NONE;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_time[i]  = r_time[i];
            lockout[i] = (i == BTN_KNOB) ? TIME_WIDTH'(i_cfg.knob_lockout)
                                         : TIME_WIDTH'(i_cfg.button_lockout);
            elapsed[i] = now_t - r_time[i];
        end
        case (t_cmd'(i_item.cmd))
            CMD_SAMPLE: begin
                if (r_prev_a && !i_item.enc_a) begin
                    if (i_item.enc_b) begin
                        n_knob = r_knob + COUNT_WIDTH'(1);
                    end else begin
                        n_knob = r_knob - COUNT_WIDTH'(1);
                    end
                end
                n_prev_a = i_item.enc_a;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    if (i_item.button_falls[i] && (elapsed[i] > lockout[i])) begin
                        n_pending[i] = 1'b1;
                        n_time[i]    = now_t;
                    end
                end
            end
            CMD_POLL_BUTTON: begin
                o_has_result = 1'b1;
                if (r_pending[0]) begin
                    n_pending[0] = 1'b0;
                    o_event_res  = EV_SAVE;
                end else if (r_pending[1]) begin
                    n_pending[1] = 1'b0;
                    o_event_res  = EV_BACK;
                end else if (r_pending[2]) begin
                    n_pending[2] = 1'b0;
                    o_event_res  = EV_PAUSE;
                end
            end
            CMD_POLL_ROTARY: begin
                o_has_result = 1'b1;
                if (r_pending[BTN_KNOB]) begin
                    n_pending[BTN_KNOB] = 1'b0;
                    o_event_res         = EV_PUSH;
                end else if (diff != '0) begin
                    n_reported  = r_knob;
                    o_event_res = diff[COUNT_WIDTH-1] ? EV_CCW : EV_CW;
                end
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

    assign o_position = knob_ext[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a   <= 1'b1;
            r_knob     <= '0;
            r_reported <= '0;
            r_pending  <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_time[i] <= '0;
            end
        end else if (i_fire) begin
            r_prev_a   <= n_prev_a;
            r_knob     <= n_knob;
            r_reported <= n_reported;
            r_pending  <= n_pending;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_time[i] <= n_time[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ sim/encoder_and_button_event_unit_test.sv @@
// Testbench for the encoder and button event unit with directed and random transactions.
`timescale 1ns / 1ps

module encoder_and_button_event_unit_test;
    import ebeu_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT = 2000;
    localparam int MAX_REPORTED = 10;

    typedef struct {
        logic [1:0]         event_res;
        logic signed [15:0] position;
    } t_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic        [1:0]  i_cmd;
    logic        [31:0] i_now_ticks;
    logic               i_enc_a;
    logic               i_enc_b;
    logic        [3:0]  i_button_falls;
    logic               o_valid;
    logic               i_stall;
    logic        [1:0]  o_event_res;
    logic signed [15:0] o_position;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic        [2:0]  paddr;
    logic        [31:0] pwdata;
    logic        [31:0] prdata;
    logic               pready;

    t_report     expected_reports[$];
    int          failures = 0;
    int          send_gap_max = 0;
    int          stall_gap_max = 0;
    int          long_hold_cycles = 0;

    logic [15:0] button_lockout;
    logic [15:0] knob_lockout;
    logic        last_enc_a;
    logic [15:0] knob_count;
    logic [15:0] reported_count;
    logic [31:0] press_time [NUM_BUTTONS];
    logic        press_pending [NUM_BUTTONS];

    int          enc_phase = 0;
    int          enc_dir = 1;
    logic [31:0] tick_base = 32'd0;

    encoder_and_button_event_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_now_ticks    (i_now_ticks),
        .i_enc_a        (i_enc_a),
        .i_enc_b        (i_enc_b),
        .i_button_falls (i_button_falls),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_res    (o_event_res),
        .o_position     (o_position),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void log_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTED) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void predict_transaction(input t_item it);
        logic [31:0] elapsed;
        logic [15:0] limit;
        logic [15:0] diff;
        t_report     rep;
        logic        found;
        rep.event_res = EV_NONE;
        case (it.cmd)
            CMD_SAMPLE: begin
                if (last_enc_a && !it.enc_a) begin
                    knob_count = it.enc_b ? knob_count + 16'd1 : knob_count - 16'd1;
                end
                last_enc_a = it.enc_a;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    if (it.button_falls[i]) begin
                        limit = (i == BTN_KNOB) ? knob_lockout : button_lockout;
                        elapsed = it.now_ticks - press_time[i];
                        if (elapsed > {16'd0, limit}) begin
                            press_pending[i] = 1'b1;
                            press_time[i] = it.now_ticks;
                        end
                    end
                end
            end
            CMD_POLL_BUTTON: begin
                found = 1'b0;
                for (int i = 0; i < BTN_KNOB; i++) begin
                    if (!found && press_pending[i]) begin
                        found = 1'b1;
                        press_pending[i] = 1'b0;
                        rep.event_res = (i == 0) ? EV_SAVE : (i == 1) ? EV_BACK : EV_PAUSE;
                    end
                end
            end
            CMD_POLL_ROTARY: begin
                if (press_pending[BTN_KNOB]) begin
                    press_pending[BTN_KNOB] = 1'b0;
                    rep.event_res = EV_PUSH;
                end else begin
                    diff = knob_count - reported_count;
                    if (diff != 16'd0) begin
                        reported_count = knob_count;
                        rep.event_res = diff[15] ? EV_CCW : EV_CW;
                    end
                end
            end
            default: ;
        endcase
        if (it.cmd == CMD_POLL_BUTTON || it.cmd == CMD_POLL_ROTARY) begin
            rep.position = knob_count;
            expected_reports.push_back(rep);
        end
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= it.cmd;
        i_now_ticks    <= it.now_ticks;
        i_enc_a        <= it.enc_a;
        i_enc_b        <= it.enc_b;
        i_button_falls <= it.button_falls;
        do @(posedge i_clk); while (o_stall);
        predict_transaction(it);
    endtask

    task automatic send_pin_sample(input logic [31:0] now, input logic a, input logic b,
                                   input logic [3:0] falls);
        t_item it;
        it.cmd          = CMD_SAMPLE;
        it.now_ticks    = now;
        it.enc_a        = a;
        it.enc_b        = b;
        it.button_falls = falls;
        send_item(it);
    endtask

    task automatic send_poll(input logic [1:0] cmd);
        t_item it;
        it              = '0;
        it.cmd          = cmd;
        it.now_ticks    = $urandom;
        it.enc_a        = last_enc_a;
        it.button_falls = 4'($urandom_range(0, 15));
        send_item(it);
    endtask

    task automatic wait_for_idle();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_reports.size() != 0) begin
            log_failure($sformatf("%0d expected results never arrived",
                                  expected_reports.size()));
            expected_reports.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_lockout(input logic reg_idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_BUTTON_LOCKOUT) begin
            button_lockout = value;
        end else begin
            knob_lockout = value;
        end
    endtask

    task automatic set_lockouts(input logic [15:0] button_ticks, input logic [15:0] knob_ticks);
        wait_for_idle();
        write_lockout(REG_BUTTON_LOCKOUT, button_ticks);
        write_lockout(REG_KNOB_LOCKOUT, knob_ticks);
    endtask

    function automatic t_item random_item();
        t_item it;
        int    pick;
        int    jump;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            it.cmd          = 2'($urandom_range(0, 3));
            it.now_ticks    = $urandom;
            it.enc_a        = 1'($urandom_range(0, 1));
            it.enc_b        = 1'($urandom_range(0, 1));
            it.button_falls = 4'($urandom_range(0, 15));
        end else if (pick < 40) begin
            it              = '0;
            it.cmd          = ($urandom_range(0, 1) == 0) ? CMD_POLL_BUTTON : CMD_POLL_ROTARY;
            it.now_ticks    = $urandom;
            it.enc_a        = 1'($urandom_range(0, 1));
            it.enc_b        = 1'($urandom_range(0, 1));
            it.button_falls = 4'($urandom_range(0, 15));
        end else begin
            jump = $urandom_range(0, 15);
            if (jump == 0) begin
                tick_base = $urandom;
            end else if (jump == 1) begin
                tick_base = tick_base + 32'($urandom_range(60000, 70000));
            end else begin
                tick_base = tick_base + 32'($urandom_range(0, 60));
            end
            if ($urandom_range(0, 7) == 0) begin
                enc_dir = -enc_dir;
            end
            if ($urandom_range(0, 7) != 0) begin
                enc_phase = (enc_phase + enc_dir + 4) % 4;
            end
            it.cmd       = CMD_SAMPLE;
            it.now_ticks = tick_base;
            it.enc_a     = (enc_phase == 0 || enc_phase == 3);
            it.enc_b     = (enc_phase < 2);
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                it.button_falls[i] = ($urandom_range(0, 5) == 0);
            end
        end
        return it;
    endfunction

    task automatic test_directed_events();
        send_gap_max  = 3;
        stall_gap_max = 3;
        send_pin_sample(32'd0, 1'b1, 1'b1, 4'hF);
        send_poll(CMD_POLL_BUTTON);
        send_poll(CMD_POLL_ROTARY);
        send_item('1);
        send_pin_sample(32'd20, 1'b1, 1'b1, 4'hF);
        send_pin_sample(32'd21, 1'b1, 1'b1, 4'hF);
        repeat (4) send_poll(CMD_POLL_BUTTON);
        send_poll(CMD_POLL_ROTARY);
        send_pin_sample(32'd201, 1'b1, 1'b1, 4'h8);
        send_pin_sample(32'd202, 1'b0, 1'b1, 4'h8);
        send_poll(CMD_POLL_BUTTON);
        send_poll(CMD_POLL_ROTARY);
        send_poll(CMD_POLL_ROTARY);
        repeat (2) begin
            send_pin_sample(32'd202, 1'b1, 1'b0, 4'h0);
            send_pin_sample(32'd202, 1'b0, 1'b0, 4'h0);
        end
        send_poll(CMD_POLL_ROTARY);
        send_pin_sample(32'hFFFF_FFFF, 1'b1, 1'b0, 4'hF);
        send_pin_sample(32'd5, 1'b1, 1'b0, 4'h7);
        send_pin_sample(32'h14, 1'b1, 1'b0, 4'h1);
        repeat (2) send_poll(CMD_POLL_BUTTON);
    endtask

    task automatic test_lockout_limits();
        set_lockouts(16'd0, 16'd0);
        send_pin_sample(32'd1000, 1'b1, 1'b0, 4'hF);
        send_pin_sample(32'd1000, 1'b1, 1'b0, 4'hF);
        repeat (4) send_poll(CMD_POLL_BUTTON);
        repeat (2) send_poll(CMD_POLL_ROTARY);
        send_pin_sample(32'd1001, 1'b1, 1'b0, 4'hF);
        set_lockouts(16'hFFFF, 16'hFFFF);
        send_pin_sample(32'd66536, 1'b1, 1'b0, 4'hF);
        send_poll(CMD_POLL_BUTTON);
        send_pin_sample(32'd66537, 1'b1, 1'b0, 4'hF);
        repeat (4) send_poll(CMD_POLL_BUTTON);
        repeat (2) send_poll(CMD_POLL_ROTARY);
    endtask

    task automatic test_position_wrap();
        send_gap_max  = 0;
        stall_gap_max = 0;
        for (int n = 1; n <= 24; n++) begin
            send_pin_sample(32'd5000, 1'b1, 1'b0, 4'h0);
            send_pin_sample(32'd5000, 1'b0, 1'b0, 4'h0);
            if (n % 6 == 0) begin
                send_poll(CMD_POLL_ROTARY);
            end
        end
        for (int n = 1; n <= 30; n++) begin
            send_pin_sample(32'd5000, 1'b1, 1'b1, 4'h0);
            send_pin_sample(32'd5000, 1'b0, 1'b1, 4'h0);
            if (n % 5 == 0) begin
                send_poll(CMD_POLL_ROTARY);
            end
        end
        send_pin_sample(32'd5000, 1'b1, 1'b1, 4'h0);
    endtask

    task automatic test_result_backpressure();
        wait_for_idle();
        send_gap_max     = 0;
        stall_gap_max    = 2;
        long_hold_cycles = 80;
        for (int n = 0; n < 40; n++) begin
            if (n % 4 == 3) begin
                send_item(random_item());
            end else begin
                send_poll((n % 2 == 0) ? CMD_POLL_BUTTON : CMD_POLL_ROTARY);
            end
        end
        wait_for_idle();
    endtask

    task automatic test_random_traffic();
        for (int round = 0; round < 9; round++) begin
            case (round)
                0: set_lockouts(BUTTON_LOCKOUT_RESET, KNOB_LOCKOUT_RESET);
                1: set_lockouts(16'd0, 16'd0);
                2: set_lockouts(16'hFFFF, 16'hFFFF);
                3: set_lockouts(16'd0, 16'hFFFF);
                4: set_lockouts(16'hFFFF, 16'd0);
                7: set_lockouts(16'($urandom), 16'($urandom));
                default: set_lockouts(16'($urandom_range(0, 40)), 16'($urandom_range(0, 300)));
            endcase
            send_gap_max  = (round % 3 == 0) ? 0 : 10;
            stall_gap_max = (round % 4 == 1) ? 0 : 10;
            for (int n = 0; n < 80; n++) begin
                send_item(random_item());
                if (n == 50 && round % 2 == 0) begin
                    wait_for_idle();
                end
            end
        end
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_cycles > 0) begin
                hold_left = long_hold_cycles;
                long_hold_cycles = 0;
            end else if (o_valid && !i_stall) begin
                hold_left = $urandom_range(0, stall_gap_max);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            i_stall <= (hold_left > 0);
        end
    end

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                log_failure($sformatf("unexpected result: event %0d position %0d",
                                      o_event_res, o_position));
            end else begin
                want = expected_reports.pop_front();
                if (o_event_res !== want.event_res || o_position !== want.position) begin
                    log_failure($sformatf(
                        "mismatch: expected event %0d position %0d, got event %0d position %0d",
                        want.event_res, want.position, o_event_res, o_position));
                end
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_SAMPLE;
        i_now_ticks    <= 32'd0;
        i_enc_a        <= 1'b1;
        i_enc_b        <= 1'b1;
        i_button_falls <= 4'h0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= 32'd0;
        button_lockout = BUTTON_LOCKOUT_RESET;
        knob_lockout   = KNOB_LOCKOUT_RESET;
        last_enc_a     = 1'b1;
        knob_count     = 16'd0;
        reported_count = 16'd0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            press_time[i]    = 32'd0;
            press_pending[i] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_events();
        test_lockout_limits();
        test_position_wrap();
        test_result_backpressure();
        test_random_traffic();

        wait_for_idle();
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
